// File: hw/rtl/length_prefixed_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed deframer
// Shared helpers that the checker uses to write its concurrent properties.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Types, codes and reset values shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned LEN_BITS_DEF = 16;
  localparam int unsigned HDR_BYTES    = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_TYPE = 2'd2;

  localparam logic [15:0] MAX_BODY_LEN_RST   = 16'd4096;
  localparam logic [31:0] MIN_FRAME_TYPE_RST = 32'd1;
  localparam logic [31:0] MAX_FRAME_TYPE_RST = 32'd5;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic ERR_OVERSIZE     = 1'b0;
  localparam logic ERR_UNKNOWN_TYPE = 1'b1;

  typedef struct packed {
    logic [15:0] max_body_len;
    logic [31:0] min_frame_type;
    logic [31:0] max_frame_type;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] frame_type;
    logic [15:0] body_len;
    logic [7:0]  data_byte;
    logic        error_code;
    logic        last;
  } result_t;

endpackage

// File: hw/rtl/lpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the length limit and the accepted message type range.
// ----------------------------------------------------------------------------
module lpd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lpd_pkg::cfg_t                 cfg
);
  import lpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BODY_LEN:   cfg_nxt.max_body_len   = cfg_wdata[15:0];
        CFG_MIN_FRAME_TYPE: cfg_nxt.min_frame_type = cfg_wdata[31:0];
        CFG_MAX_FRAME_TYPE: cfg_nxt.max_frame_type = cfg_wdata[31:0];
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_body_len   <= MAX_BODY_LEN_RST;
      cfg_r.min_frame_type <= MIN_FRAME_TYPE_RST;
      cfg_r.max_frame_type <= MAX_FRAME_TYPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/lpd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Gathers the header, checks it, and counts payload bytes through.
// ----------------------------------------------------------------------------
module lpd_parser #(
  parameter int unsigned LEN_BITS = lpd_pkg::LEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lpd_pkg::cfg_t    cfg,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output lpd_pkg::result_t res
);
  import lpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ERROR   = 3'b100
  } phase_t;

  localparam int unsigned SHIFT_W = (HDR_BYTES - 1) * 8;
  localparam logic [32:0] LEN_MAX = (33'd1 << LEN_BITS) - 33'd1;

  phase_t              phase_r, phase_nxt;
  logic [2:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [LEN_BITS-1:0] remain_r, remain_nxt;

  logic [31:0]         hdr_type;
  logic [31:0]         hdr_len;
  logic [32:0]         cfg_limit;
  logic [32:0]         limit;
  logic                oversize;
  logic                bad_type;
  logic [LEN_BITS-1:0] remain_dec;

  assign hdr_type   = shift_r[SHIFT_W-1 -: 32];
  assign hdr_len    = {shift_r[23:0], rx_byte};
  assign cfg_limit  = {17'd0, cfg.max_body_len};
  assign limit      = (cfg_limit > LEN_MAX) ? LEN_MAX : cfg_limit;
  assign oversize   = {1'b0, hdr_len} > limit;
  assign bad_type   = (hdr_type < cfg.min_frame_type) || (hdr_type > cfg.max_frame_type);
  assign remain_dec = remain_r - {{(LEN_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    shift_nxt      = shift_r;
    remain_nxt     = remain_r;
    res_valid      = 1'b0;
    res.kind       = KIND_DATA;
    res.frame_type = 32'd0;
    res.body_len   = 16'd0;
    res.data_byte  = 8'd0;
    res.error_code = ERR_OVERSIZE;
    res.last       = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_PAYLOAD: begin
          remain_nxt    = remain_dec;
          res_valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = rx_byte;
          res.last      = (remain_dec == '0);
          if (remain_dec == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          shift_nxt   = {shift_r[SHIFT_W-9:0], rx_byte};
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          if (hdr_cnt_r == 3'(HDR_BYTES - 1)) begin
            res_valid = 1'b1;
            priority if (oversize) begin
              phase_nxt      = PH_ERROR;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_OVERSIZE;
            end else if (bad_type) begin
              phase_nxt      = PH_ERROR;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_UNKNOWN_TYPE;
            end else begin
              remain_nxt     = hdr_len[LEN_BITS-1:0];
              phase_nxt      = (hdr_len == 32'd0) ? PH_HEADER : PH_PAYLOAD;
              res.kind       = KIND_HEADER;
              res.frame_type = hdr_type;
              res.body_len   = hdr_len[15:0];
              res.last       = (hdr_len == 32'd0);
            end
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 3'd0;
      remain_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      remain_r  <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

endmodule

// File: hw/rtl/lpd_out_buf.sv
// ----------------------------------------------------------------------------
// Deframer result buffer
// Output register with a skid stage that takes one more input beat under stall.
// ----------------------------------------------------------------------------
module lpd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lpd_pkg::result_t push_res,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output lpd_pkg::result_t out_res
);
  import lpd_pkg::*;

  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_res_r, out_res_nxt;
  result_t skid_res_r, skid_res_nxt;
  logic    drain;

  assign can_take = !skid_vld_r;
  assign drain    = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (drain) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_res_nxt = push_res;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

endmodule

// File: hw/rtl/length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed message deframer
// Splits a byte stream into header, payload and error beats.
//
//   Channel  Ports                         Beat
//   in       in_valid/in_ready             one received byte
//   out      out_valid/out_ready           header, payload byte or error
//   cfg      cfg_we/cfg_index/cfg_wdata    register write, no wait
//
// One input beat per cycle while the skid stage has room; each result is
// registered in the output buffer. Header, length and phase state update
// once per accepted byte. Reset is synchronous; it restores register
// defaults and clears the sticky error. A stalled output holds one result
// plus one in the skid stage; input ready drops only while it is full.
// ----------------------------------------------------------------------------
module length_prefixed_deframer #(
  parameter int unsigned LEN_BITS = lpd_pkg::LEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [31:0]                   out_frame_type,
  output logic [15:0]                   out_body_len,
  output logic [7:0]                    out_data_byte,
  output logic                          out_error_code,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpd_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = in_valid && in_ready;

  lpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_frame_type = out_res.frame_type;
  assign out_body_len   = out_res.body_len;
  assign out_data_byte  = out_res.data_byte;
  assign out_error_code = out_res.error_code;
  assign out_last       = out_res.last;

endmodule

// File: hw/rtl/lpd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level ports for result ordering and stall rules.
// ----------------------------------------------------------------------------
`include "length_prefixed_deframer_macros.svh"

module lpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_frame_type,
  input logic [15:0] out_body_len,
  input logic [7:0]  out_data_byte,
  input logic        out_error_code,
  input logic        out_last
);
  import lpd_pkg::*;

  logic [59:0] out_beat;
  logic        out_stall;
  logic        kind_ok;
  logic        hdr_beat;
  logic        err_beat;
  logic        err_fire;

  assign out_beat  = {out_kind, out_frame_type, out_body_len, out_data_byte,
                      out_error_code, out_last};
  assign out_stall = out_valid && !out_ready;
  assign kind_ok   = (out_kind == KIND_HEADER) || (out_kind == KIND_DATA) ||
                     (out_kind == KIND_ERROR);
  assign hdr_beat  = out_valid && (out_kind == KIND_HEADER);
  assign err_beat  = out_valid && (out_kind == KIND_ERROR);
  assign err_fire  = err_beat && out_ready;

  `LPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_beat))
  `LPD_ASSERT_SAME(a_kind_legal, clk, rst_n, out_valid, kind_ok)
  `LPD_ASSERT_SAME(a_err_not_last, clk, rst_n, err_beat, !out_last)
  `LPD_ASSERT_SAME(a_hdr_last, clk, rst_n, hdr_beat, out_last == (out_body_len == 16'd0))
  `LPD_ASSERT_NEXT(a_err_final, clk, rst_n, err_fire, !out_valid)

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (.*);
